@@ rtl/core/ppm_frame_decoder_core_assert.svh @@
// Assertion macros for the PPM frame decoder core.
// Used by the top level; no other dependencies.
`ifndef PPM_FRAME_DECODER_CORE_ASSERT_SVH
`define PPM_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PPM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppm assertion failed");

// Next-cycle implication, disabled during reset
`define PPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ppm assertion failed");

`endif

@@ rtl/core/ppm_pkg.sv @@
// Shared types and constants for the PPM frame decoder core.
// No dependencies.
package ppm_pkg;

  localparam int unsigned ValW  = 16;
  localparam int unsigned CfgAW = 3;

  // Configuration register indexes
  localparam logic [CfgAW-1:0] CFG_SYNC_GAP  = 3'd0;
  localparam logic [CfgAW-1:0] CFG_PULSE_MIN = 3'd1;
  localparam logic [CfgAW-1:0] CFG_PULSE_MAX = 3'd2;
  localparam logic [CfgAW-1:0] CFG_DB_LOW    = 3'd3;
  localparam logic [CfgAW-1:0] CFG_DB_HIGH   = 3'd4;
  localparam logic [CfgAW-1:0] CFG_DB_CENTRE = 3'd5;
  localparam logic [CfgAW-1:0] CFG_SW_THRESH = 3'd6;
  localparam logic [CfgAW-1:0] CFG_SW_CHAN   = 3'd7;

  // Reset values of the configuration registers
  localparam logic [ValW-1:0] RST_SYNC_GAP  = 16'd2100;
  localparam logic [ValW-1:0] RST_PULSE_MIN = 16'd9;
  localparam logic [ValW-1:0] RST_PULSE_MAX = 16'd2050;
  localparam logic [ValW-1:0] RST_DB_LOW    = 16'd1350;
  localparam logic [ValW-1:0] RST_DB_HIGH   = 16'd1650;
  localparam logic [ValW-1:0] RST_DB_CENTRE = 16'd1500;
  localparam logic [ValW-1:0] RST_SW_THRESH = 16'd1700;
  localparam logic [2:0]      RST_SW_CHAN   = 3'd5;

  // Result of the shared subtract/compare unit
  typedef struct packed {
    logic [ValW-1:0] diff;
    logic            lt;   // a < b
    logic            eq;   // a == b
  } alu_res_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTV,
    ST_SYNC,
    ST_PMIN,
    ST_PMAX,
    ST_RD,
    ST_DLO,
    ST_DHI,
    ST_SWCMP,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/core/ppm_frame_decoder_core.sv @@
// PPM frame decoder core: edge timestamps in, decoded channel values out.
//
// Input channel: in_tdata carries one edge timestamp (us, wrapping at 2^16).
// Output channel: one transfer per channel when a frame completes, index in
// out_tdata, frame end on out_tlast, switch flag on out_tuser.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// write only while the block is idle.
//
// Sequence: an edge that does not finish a frame holds the input while the
// shared subtract/compare unit forms the interval and runs the sync test and
// the pulse range tests. An edge that finishes a frame then reads, dead-bands
// and compares the switch channel (if it exists), then for each channel reads
// the store, makes two dead-band compares and loads the output register.
// in_tready is high only while the sequencer is idle.
// A stalled receiver holds the output register; the sequencer waits for the
// slot before loading the next channel.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the frame state and switch flag; the channel store is not cleared.
module ppm_frame_decoder_core #(
  parameter int unsigned CHANNELS          = 8,
  parameter int unsigned DEADBAND_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] edge_time
  // output channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] channel_index, [18:3] channel_value, zero pad
  output logic        out_tlast,  // frame_last
  output logic        out_tuser,  // [0] switch_on
  // configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ppm_pkg::*;

  `include "ppm_frame_decoder_core_assert.svh"

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LastCh = CW'(CHANNELS - 1);

  // Configuration registers
  logic [ValW-1:0] sync_gap_r, pulse_min_r, pulse_max_r;
  logic [ValW-1:0] db_low_r, db_high_r, db_centre_r, sw_thresh_r;
  logic [2:0]      sw_chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_gap_r  <= RST_SYNC_GAP;
      pulse_min_r <= RST_PULSE_MIN;
      pulse_max_r <= RST_PULSE_MAX;
      db_low_r    <= RST_DB_LOW;
      db_high_r   <= RST_DB_HIGH;
      db_centre_r <= RST_DB_CENTRE;
      sw_thresh_r <= RST_SW_THRESH;
      sw_chan_r   <= RST_SW_CHAN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SYNC_GAP:  sync_gap_r  <= cfg_wdata;
        CFG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        CFG_PULSE_MAX: pulse_max_r <= cfg_wdata;
        CFG_DB_LOW:    db_low_r    <= cfg_wdata;
        CFG_DB_HIGH:   db_high_r   <= cfg_wdata;
        CFG_DB_CENTRE: db_centre_r <= cfg_wdata;
        CFG_SW_THRESH: sw_thresh_r <= cfg_wdata;
        CFG_SW_CHAN:   sw_chan_r   <= cfg_wdata[2:0];
        default:       ;
      endcase
    end
  end

  // Sequencer and datapath state
  state_t          state_r, state_nxt;
  logic [ValW-1:0] now_r, now_nxt;
  logic [ValW-1:0] last_edge_r, last_edge_nxt;
  logic [ValW-1:0] intv_r, intv_nxt;
  logic            armed_r, armed_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            emit_r, emit_nxt;
  logic            gtlo_r, gtlo_nxt;
  logic [ValW-1:0] val_r, val_nxt;
  logic            flag_r, flag_nxt;

  // Output register
  logic            ovalid_r, ovalid_nxt;
  logic [CW-1:0]   oidx_r, oidx_nxt;
  logic [ValW-1:0] oval_r, oval_nxt;
  logic            olast_r, olast_nxt;
  logic            oflag_r, oflag_nxt;

  // Shared unit and store
  logic [ValW-1:0] op_a, op_b;
  alu_res_t        alu;
  logic            ram_we, ram_re;
  logic [CW-1:0]   ram_raddr;
  logic [ValW-1:0] ram_rdata;

  ppm_alu u_alu (
    .op_a (op_a),
    .op_b (op_b),
    .res  (alu)
  );

  ppm_ram #(
    .WIDTH (ValW),
    .DEPTH (CHANNELS),
    .AW    (CW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r),
    .wdata (intv_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Switch channel as a store address, and whether it exists
  logic [CW+2:0] sw_ext;
  logic [CW-1:0] sw_addr;
  logic          sw_valid;
  logic [CW-1:0] snap_idx;
  logic          snap_en;
  logic          out_free;

  assign sw_ext   = {{CW{1'b0}}, sw_chan_r};
  assign sw_addr  = sw_ext[CW-1:0];
  assign sw_valid = (32'(sw_chan_r) < CHANNELS);
  assign snap_idx = emit_r ? idx_r : sw_addr;
  assign snap_en  = (32'(snap_idx) < DEADBAND_CHANNELS);
  assign out_free = !ovalid_r || out_tready;

  // Advance state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_edge_r <= '0;
      armed_r     <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      emit_r      <= 1'b0;
      flag_r      <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_edge_r <= last_edge_nxt;
      armed_r     <= armed_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      emit_r      <= emit_nxt;
      flag_r      <= flag_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    intv_r  <= intv_nxt;
    gtlo_r  <= gtlo_nxt;
    val_r   <= val_nxt;
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    oflag_r <= oflag_nxt;
  end

  // Next state, operand selection and store control
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    last_edge_nxt = last_edge_r;
    intv_nxt      = intv_r;
    armed_nxt     = armed_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    emit_nxt      = emit_r;
    gtlo_nxt      = gtlo_r;
    val_nxt       = val_r;
    flag_nxt      = flag_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    oidx_nxt      = oidx_r;
    oval_nxt      = oval_r;
    olast_nxt     = olast_r;
    oflag_nxt     = oflag_r;
    op_a          = now_r;
    op_b          = last_edge_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = snap_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          now_nxt   = in_tdata;
          state_nxt = ST_INTV;
        end
      end
      // interval = now - last edge, modulo 2^16
      ST_INTV: begin
        intv_nxt      = alu.diff;
        last_edge_nxt = now_r;
        state_nxt     = ST_SYNC;
      end
      ST_SYNC: begin
        op_a = intv_r;
        op_b = sync_gap_r;
        if (!alu.lt) begin
          armed_nxt = 1'b1;
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end else if (armed_r) begin
          state_nxt = ST_PMIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PMIN: begin
        op_a = intv_r;
        op_b = pulse_min_r;
        if (alu.lt) begin
          armed_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PMAX;
        end
      end
      // Store the channel; start the frame output after the last one
      ST_PMAX: begin
        op_a = pulse_max_r;
        op_b = intv_r;
        if (alu.lt) begin
          armed_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          ram_we = 1'b1;
          if (count_r == LastCh) begin
            armed_nxt = 1'b0;
            count_nxt = '0;
            idx_nxt   = '0;
            emit_nxt  = !sw_valid;
            state_nxt = ST_RD;
          end else begin
            count_nxt = CW'(count_r + 1'b1);
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_DLO;
      end
      // Dead band: low < v
      ST_DLO: begin
        op_a      = db_low_r;
        op_b      = ram_rdata;
        gtlo_nxt  = alu.lt;
        state_nxt = ST_DHI;
      end
      // Dead band: v < high, then snap
      ST_DHI: begin
        op_a      = ram_rdata;
        op_b      = db_high_r;
        val_nxt   = (snap_en && gtlo_r && alu.lt) ? db_centre_r : ram_rdata;
        state_nxt = emit_r ? ST_EMIT : ST_SWCMP;
      end
      // Update the switch flag; equality holds it
      ST_SWCMP: begin
        op_a = val_r;
        op_b = sw_thresh_r;
        if (alu.lt) begin
          flag_nxt = 1'b0;
        end else if (!alu.eq) begin
          flag_nxt = 1'b1;
        end
        emit_nxt  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_RD;
      end
      // Load the output register when the slot is free
      ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oidx_nxt   = idx_r;
          oval_nxt   = val_r;
          olast_nxt  = (idx_r == LastCh);
          oflag_nxt  = flag_r;
          if (idx_r == LastCh) begin
            emit_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = CW'(idx_r + 1'b1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive ports
  logic [CW+2:0] oidx_ext;
  assign oidx_ext   = {3'b000, oidx_r};
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'b00000, oval_r, oidx_ext[2:0]};
  assign out_tlast  = olast_r;
  assign out_tuser  = oflag_r;

  // Checks
  `PPM_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == ST_INTV)
  `PPM_ASSERT_SAME(a_store_when_armed, clk, rst_n, ram_we, armed_r)
  `PPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PPM_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, 32'(count_r) < CHANNELS)

endmodule

@@ rtl/core/ppm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ppm_alu.sv @@
// Shared 16-bit subtract and compare unit of the PPM frame decoder.
// Depends on ppm_pkg.
module ppm_alu (
  input  logic [ppm_pkg::ValW-1:0] op_a,
  input  logic [ppm_pkg::ValW-1:0] op_b,
  output ppm_pkg::alu_res_t        res
);
  import ppm_pkg::*;

  logic [ValW:0] sum;

  // One wide subtract; the borrow gives a < b
  assign sum      = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff = sum[ValW-1:0];
  assign res.lt   = sum[ValW];
  assign res.eq   = (sum[ValW-1:0] == '0);

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for ppm_frame_decoder_core: drives edge timestamps and register
// settings, predicts every decoded channel transfer and compares it field by field.
// Depends on ppm_pkg for register indexes and reset values.

import ppm_pkg::*;

// Scoreboard: shadow copy of the decoder state plus the queue of channels still due
class ppm_frame_model;
  localparam int unsigned NumChans = 8;
  localparam int unsigned DbChans  = 4;

  typedef struct {
    logic [2:0]  chan_idx;
    logic [15:0] chan_val;
    logic        last;
    logic        sw_on;
  } chan_xfer_t;

  logic [15:0] sync_gap;
  logic [15:0] pulse_min;
  logic [15:0] pulse_max;
  logic [15:0] db_low;
  logic [15:0] db_high;
  logic [15:0] db_centre;
  logic [15:0] sw_thresh;
  logic [2:0]  sw_chan;

  logic [15:0] last_stamp;
  bit          armed;
  int unsigned chan_cnt;
  logic [15:0] chan_store [NumChans];
  bit          sw_flag;

  chan_xfer_t  due_q [$];
  int unsigned errors;

  function new();
    sync_gap   = RST_SYNC_GAP;
    pulse_min  = RST_PULSE_MIN;
    pulse_max  = RST_PULSE_MAX;
    db_low     = RST_DB_LOW;
    db_high    = RST_DB_HIGH;
    db_centre  = RST_DB_CENTRE;
    sw_thresh  = RST_SW_THRESH;
    sw_chan    = RST_SW_CHAN;
    last_stamp = '0;
    armed      = 1'b0;
    chan_cnt   = 0;
    sw_flag    = 1'b0;
    errors     = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_SYNC_GAP:  sync_gap  = val;
      CFG_PULSE_MIN: pulse_min = val;
      CFG_PULSE_MAX: pulse_max = val;
      CFG_DB_LOW:    db_low    = val;
      CFG_DB_HIGH:   db_high   = val;
      CFG_DB_CENTRE: db_centre = val;
      CFG_SW_THRESH: sw_thresh = val;
      CFG_SW_CHAN:   sw_chan   = val[2:0];
      default: ;
    endcase
  endfunction

  // Advance the frame state on one accepted edge; queue a full frame when it completes
  function void note_edge(logic [15:0] stamp);
    logic [15:0] gap;
    logic [15:0] vals [NumChans];
    chan_xfer_t  x;
    gap = stamp - last_stamp;
    last_stamp = stamp;
    if (armed) begin
      // sync test wins over the pulse range test
      if (gap >= sync_gap) begin
        chan_cnt = 0;
      end else if (gap >= pulse_min && gap <= pulse_max) begin
        chan_store[chan_cnt] = gap;
        chan_cnt++;
        if (chan_cnt >= NumChans) begin
          armed = 1'b0;
          chan_cnt = 0;
          // snap low channels strictly inside the dead band
          for (int i = 0; i < NumChans; i++) begin
            if (i < DbChans && chan_store[i] > db_low && chan_store[i] < db_high)
              vals[i] = db_centre;
            else
              vals[i] = chan_store[i];
          end
          // hold the flag on equality
          if (vals[sw_chan] < sw_thresh)
            sw_flag = 1'b0;
          else if (vals[sw_chan] > sw_thresh)
            sw_flag = 1'b1;
          for (int i = 0; i < NumChans; i++) begin
            x.chan_idx = i[2:0];
            x.chan_val = vals[i];
            x.last     = (i == NumChans - 1);
            x.sw_on    = sw_flag;
            due_q.push_back(x);
          end
        end
      end else begin
        armed = 1'b0;
      end
    end else if (gap >= sync_gap) begin
      armed = 1'b1;
      chan_cnt = 0;
    end
  endfunction

  // Compare one output transfer with the oldest channel due
  function void check_result(logic [23:0] tdata, logic tlast, logic tuser);
    chan_xfer_t x;
    if (due_q.size() == 0) begin
      $error("unexpected channel transfer: tdata=%h tlast=%b tuser=%b", tdata, tlast, tuser);
      errors++;
      return;
    end
    x = due_q.pop_front();
    if (tdata[2:0] !== x.chan_idx) begin
      $error("channel_index: expected %0d, actual %0d", x.chan_idx, tdata[2:0]);
      errors++;
    end
    if (tdata[18:3] !== x.chan_val) begin
      $error("channel_value: expected %0d, actual %0d", x.chan_val, tdata[18:3]);
      errors++;
    end
    if (tlast !== x.last) begin
      $error("frame_last: expected %b, actual %b", x.last, tlast);
      errors++;
    end
    if (tuser !== x.sw_on) begin
      $error("switch_on: expected %b, actual %b", x.sw_on, tuser);
      errors++;
    end
  endfunction
endclass

module tb_top;
  // settle time after the last due channel; covers any edge still in flight
  localparam int SettleCycles = 60;

  typedef enum {
    SET_DEFAULT,
    SET_TYPICAL,
    SET_WIDE,
    SET_DEGENERATE,
    SET_OVERLAP
  } setting_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  ppm_frame_model model;
  logic [15:0]    cur_stamp;
  logic [15:0]    reg_set [8];
  logic [15:0]    directed_gaps [25];
  bit             no_idle;
  int             hold_req;
  int             hold_cnt;

  ppm_frame_decoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample output transfers on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      model.check_result(out_tdata, out_tlast, out_tuser);
  end

  // Drive ready on the falling edge: random stalls, or a counted hold-off on request
  initial begin
    hold_cnt = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else if (hold_req > 0) begin
        hold_cnt = hold_req - 1;
        hold_req = 0;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  initial begin
    #3000000;
    $display("ppm_frame_decoder_core regression: fail");
    $finish;
  end

  // Offer one timestamp, idling at random first; valid stays high on return
  task automatic send_stamp(input logic [15:0] stamp);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model.note_edge(stamp);
    @(negedge clk);
  endtask

  task automatic send_gap(input logic [15:0] gap);
    cur_stamp = cur_stamp + gap;
    send_stamp(cur_stamp);
  endtask

  // Drop valid, wait until every due channel has arrived, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (model.due_q.size() > 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Pick a register set and write every register, one per cycle
  task automatic apply_settings(input setting_kind_t kind);
    case (kind)
      SET_DEFAULT: begin
        reg_set = '{RST_SYNC_GAP, RST_PULSE_MIN, RST_PULSE_MAX, RST_DB_LOW,
                    RST_DB_HIGH, RST_DB_CENTRE, RST_SW_THRESH, 16'(RST_SW_CHAN)};
      end
      SET_TYPICAL: begin
        reg_set[CFG_SYNC_GAP]  = 16'($urandom_range(5000, 2500));
        reg_set[CFG_PULSE_MIN] = 16'($urandom_range(900, 0));
        reg_set[CFG_PULSE_MAX] = 16'($urandom_range(2400, 1800));
        reg_set[CFG_DB_LOW]    = 16'($urandom_range(1500, 1000));
        reg_set[CFG_DB_HIGH]   = reg_set[CFG_DB_LOW] + 16'($urandom_range(400, 0));
        reg_set[CFG_DB_CENTRE] = 16'($urandom_range(2000, 1000));
        reg_set[CFG_SW_THRESH] = ($urandom_range(0, 3) == 0) ? reg_set[CFG_DB_CENTRE]
                                                             : 16'($urandom_range(2200, 1000));
        reg_set[CFG_SW_CHAN]   = 16'($urandom_range(7, 0));
      end
      SET_WIDE: begin
        reg_set = '{16'hFFFF, 16'h0000, 16'hFFFE, 16'h0000,
                    16'hFFFF, 16'h0000, 16'h0000, 16'd0};
        if ($urandom_range(0, 1)) reg_set[CFG_DB_CENTRE] = 16'hFFFF;
      end
      SET_DEGENERATE: begin
        // every interval is a sync, empty pulse range, empty dead band
        reg_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                    16'h0000, 16'h1234, 16'hFFFF, 16'd7};
      end
      SET_OVERLAP: begin
        // pulse range reaches past the sync gap; dead band bounds one apart, none inside
        reg_set = '{16'd1000, 16'd500, 16'd3000, 16'd1500,
                    16'd1501, 16'd1500, 16'hFFFF, 16'd3};
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[2:0];
      cfg_wdata <= (i == CFG_SW_CHAN) ? (reg_set[i] & 16'h7) : reg_set[i];
      model.write_reg(i[2:0], (i == CFG_SW_CHAN) ? (reg_set[i] & 16'h7) : reg_set[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] sync_interval();
    if ($urandom_range(0, 3) == 0) return model.sync_gap;
    return 16'($urandom_range(65535, model.sync_gap));
  endfunction

  // Interval outside the pulse range, below or above it
  function automatic logic [15:0] bad_interval();
    if (model.pulse_min > 0 && $urandom_range(0, 1))
      return 16'($urandom_range(model.pulse_min - 1, 0));
    if (model.pulse_max < 16'hFFFF)
      return 16'($urandom_range(65535, model.pulse_max + 1));
    return 16'($urandom);
  endfunction

  // Interval inside the pulse range, biased toward the dead band and threshold edges
  function automatic logic [15:0] pulse_interval();
    logic [15:0] hi;
    logic [15:0] v;
    hi = model.pulse_max;
    if (model.sync_gap > 0 && hi >= model.sync_gap && $urandom_range(0, 9) != 0)
      hi = model.sync_gap - 1;
    if (model.pulse_min > hi) return 16'($urandom);
    case ($urandom_range(0, 12))
      0: v = model.db_low;
      1: v = model.db_low + 1;
      2: v = model.db_high - 1;
      3: v = model.db_high;
      4: v = model.db_centre;
      5: v = model.sw_thresh;
      6: v = model.sw_thresh - 1;
      7: v = model.sw_thresh + 1;
      8: v = model.pulse_min;
      9: v = hi;
      default: v = 16'($urandom_range(hi, model.pulse_min));
    endcase
    if (v < model.pulse_min || v > hi) v = 16'($urandom_range(hi, model.pulse_min));
    return v;
  endfunction

  // Mostly whole frames with random content; the rest noise and broken frames
  task automatic run_random(input int budget);
    int n;
    int roll;
    int pick;
    n = 0;
    while (n < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_gap(sync_interval());
        n++;
        for (int k = 0; k < 8; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) send_gap(bad_interval());
          else if (pick < 7) send_gap(sync_interval());
          else send_gap(pulse_interval());
          n++;
        end
      end else if (roll < 85) begin
        cur_stamp = 16'($urandom);
        send_stamp(cur_stamp);
        n++;
      end else begin
        send_gap(sync_interval());
        n++;
        repeat ($urandom_range(6, 0)) begin
          send_gap(pulse_interval());
          n++;
        end
        send_gap(bad_interval());
        n++;
      end
    end
  endtask

  initial begin
    model     = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    cur_stamp = '0;
    no_idle   = 1'b0;
    hold_req  = 0;
    // sync from time 0, extremes, dead band edges, switch equality, restart, disarm
    directed_gaps = '{16'd2100, 16'd9, 16'd2050, 16'd1351, 16'd1649, 16'd1500,
                      16'd1700, 16'd1350, 16'd1650,
                      16'd3000, 16'd1000, 16'd1100, 16'd1200,
                      16'd2100, 16'd1000, 16'd1400, 16'd1600, 16'd1350,
                      16'd1000, 16'd1701, 16'd1000, 16'd1000,
                      16'd2200, 16'd2051, 16'd8};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass under reset settings
    foreach (directed_gaps[i]) send_gap(directed_gaps[i]);
    drain();

    // no idling on either side for this stretch
    no_idle = 1'b1;
    apply_settings(SET_TYPICAL);
    run_random(22);
    drain();
    no_idle = 1'b0;

    // long receiver hold-off while frames keep coming
    apply_settings(SET_TYPICAL);
    hold_req = 400;
    run_random(22);
    drain();

    apply_settings(SET_WIDE);
    run_random(22);
    drain();

    apply_settings(SET_DEGENERATE);
    run_random(12);
    drain();

    apply_settings(SET_OVERLAP);
    run_random(22);
    drain();

    // pause the sender mid-phase until all channels are out
    apply_settings(SET_TYPICAL);
    run_random(15);
    drain();
    run_random(15);
    drain();

    apply_settings(SET_WIDE);
    run_random(22);
    drain();

    apply_settings(SET_TYPICAL);
    run_random(22);
    drain();

    apply_settings(SET_DEFAULT);
    run_random(22);
    drain();

    if (model.errors == 0 && model.due_q.size() == 0)
      $display("ppm_frame_decoder_core regression: pass");
    else
      $display("ppm_frame_decoder_core regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ppm_pkg.sv
rtl/core/ppm_ram.sv
rtl/core/ppm_alu.sv
rtl/core/ppm_frame_decoder_core.sv
tb/sv/tb_top.sv
